@@ src/wnm_pkg.sv @@
// Shared types and constants for the wildcard name matcher.
// Used by the matcher cell, the result register, the top level and the checker.
package wnm_pkg;

  // Special pattern and name bytes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Default pattern capacity in bytes
  localparam int DEF_PATTERN_LEN = 16;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_REG_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  // Bytes held in the two pattern registers
  localparam int REG_BYTES = 8;
  localparam int STORED_BYTES = 2 * REG_BYTES;

  // Signals handed from one cell to the next along the chain
  typedef struct packed {
    logic take_a;   // full set: position advances into the next cell
    logic take_s;   // stripped set: position advances into the next cell
    logic carry_a;  // full set: star closure continues
    logic carry_s;  // stripped set: star closure continues
    logic carry_z;  // start set: star closure continues
  } wnm_link_t;

  // Per-cycle update commands broadcast to every cell
  typedef struct packed {
    logic a_from_start;  // feed the full set starting from the start set
    logic load_a;        // store the fed full set
    logic load_s_start;  // store the start set as the stripped set
    logic load_s_feed;   // store the fed stripped set
  } wnm_ctl_t;

  // Per-cell bits that the top level samples at the pattern length
  typedef struct packed {
    logic z;        // start set
    logic a_close;  // fed full set
    logic s_close;  // fed stripped set
    logic s_cur;    // stored stripped set
  } wnm_tap_t;

endpackage

@@ src/wnm_cell.sv @@
// One pattern position of the NFA chain: holds its bit of the full and the
// stripped position sets and passes advance and star closure to its neighbor.
// Depends on wnm_pkg.
module wnm_cell (
  input  logic               clk,
  input  logic [7:0]         pat_byte,
  input  logic               en,
  input  logic [7:0]         char_a,
  input  logic [7:0]         char_s,
  input  wnm_pkg::wnm_ctl_t  ctl,
  input  wnm_pkg::wnm_link_t link_in,
  output wnm_pkg::wnm_link_t link_out,
  output wnm_pkg::wnm_tap_t  tap
);
  import wnm_pkg::*;

  logic a_q;
  logic s_q;
  logic is_star;
  logic is_qmark;
  logic close_z;
  logic src_a;
  logic close_a;
  logic close_s;

  assign is_star  = en && (pat_byte == CH_STAR);
  assign is_qmark = (pat_byte == CH_QMARK);

  // Start set: position zero plus star closure
  assign close_z = link_in.carry_z;

  assign src_a   = ctl.a_from_start ? close_z : a_q;
  assign close_a = (src_a && is_star) || link_in.take_a || link_in.carry_a;
  assign close_s = (s_q && is_star) || link_in.take_s || link_in.carry_s;

  assign link_out.take_a  = src_a && en && (is_qmark || pat_byte == char_a);
  assign link_out.take_s  = s_q && en && (is_qmark || pat_byte == char_s);
  assign link_out.carry_a = close_a && is_star;
  assign link_out.carry_s = close_s && is_star;
  assign link_out.carry_z = close_z && is_star;

  assign tap.z       = close_z;
  assign tap.a_close = close_a;
  assign tap.s_close = close_s;
  assign tap.s_cur   = s_q;

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      a_q <= close_a;
    end
    if (ctl.load_s_start) begin
      s_q <= close_z;
    end else if (ctl.load_s_feed) begin
      s_q <= close_s;
    end
  end

endmodule

@@ src/wnm_result_reg.sv @@
// Output register for the match result: holds one result until it is taken
// and tells the input side whether a new item may enter. Depends on wnm_pkg.
module wnm_result_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       matched_in,
  input  logic       m_tready,
  output logic       m_tvalid,
  output logic [7:0] m_tdata,   // [0] matched, [7:1] zero
  output logic       space
);
  import wnm_pkg::*;

  logic matched_q;

  assign space   = !m_tvalid || m_tready;
  assign m_tdata = {7'b0, matched_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      matched_q <= matched_in;
    end
  end

endmodule

@@ src/wildcard_name_matcher_core.sv @@
// Wildcard name matcher: glob match of a byte-streamed name against a pattern.
// Result: the match flag appears on m_* in the cycle after the name's last item is accepted.
// Throughput: one item per cycle; s_tready drops only while a result waits untaken.
// Speed is set by the ripple along the cell chain (start closure, then feed and closure).
// Reset (rst, synchronous): clears pattern registers, name state and the result valid.
// Depends on wnm_pkg, wnm_cell and wnm_result_reg.
module wildcard_name_matcher_core #(
  parameter int PATTERN_LEN = wnm_pkg::DEF_PATTERN_LEN
) (
  input  logic                           clk,
  input  logic                           rst,
  // name input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] text_char
  input  logic                           s_tlast,   // last_char
  input  logic [0:0]                     s_tuser,   // [0] empty_name
  // result output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [0] matched, [7:1] zero
  // configuration
  input  logic                           cfg_we,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wnm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wnm_pkg::*;

  localparam int NUM_POS = PATTERN_LEN + 1;
  localparam int LEN_W   = $clog2(PATTERN_LEN + 1);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_REG_W-1:0]  pattern_length;

  // Name state
  logic       at_start;
  logic       opened;
  logic       held_valid;
  logic [7:0] held_byte;

  logic [LEN_W-1:0]   eff_len;
  logic [NUM_POS-1:0] pos_en;
  logic [7:0]         pat_bytes [NUM_POS];
  wnm_link_t          link [NUM_POS+1];
  wnm_tap_t           taps [NUM_POS];
  logic [NUM_POS-1:0] z_vec;
  logic [NUM_POS-1:0] a_close_vec;
  logic [NUM_POS-1:0] s_close_vec;
  logic [NUM_POS-1:0] s_cur_vec;
  wnm_ctl_t           ctl;

  logic       fire;
  logic       space;
  logic       empty_name;
  logic       is_dquote;
  logic       closing;
  logic       res_load;
  logic       res_matched;
  logic       restart;

  logic       at_start_next;
  logic       opened_next;
  logic       held_valid_next;

  // ---------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the length at the pattern capacity
  always_comb begin
    if (32'(pattern_length) > PATTERN_LEN) begin
      eff_len = LEN_W'(PATTERN_LEN);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  // ---------------------------------------------------------------
  // Cell chain: one cell per pattern position plus the accept position
  // ---------------------------------------------------------------
  assign link[0] = '{take_a: 1'b0, take_s: 1'b0, carry_a: 1'b0, carry_s: 1'b0,
                     carry_z: 1'b1};

  for (genvar i = 0; i < NUM_POS; i++) begin : g_cell
    // Bytes past the two pattern registers read as zero
    if (i < REG_BYTES) begin : g_lo
      assign pat_bytes[i] = pattern_low[8*i +: 8];
    end else if (i < STORED_BYTES) begin : g_hi
      assign pat_bytes[i] = pattern_high[8*(i-REG_BYTES) +: 8];
    end else begin : g_zero
      assign pat_bytes[i] = 8'h00;
    end

    // Only positions below the length take part
    assign pos_en[i] = (32'(eff_len) > i);

    wnm_cell u_cell (
      .clk      (clk),
      .pat_byte (pat_bytes[i]),
      .en       (pos_en[i]),
      .char_a   (s_tdata),
      .char_s   (held_byte),
      .ctl      (ctl),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .tap      (taps[i])
    );

    assign z_vec[i]       = taps[i].z;
    assign a_close_vec[i] = taps[i].a_close;
    assign s_close_vec[i] = taps[i].s_close;
    assign s_cur_vec[i]   = taps[i].s_cur;
  end

  // ---------------------------------------------------------------
  // Item control
  // ---------------------------------------------------------------
  assign fire       = s_tvalid && s_tready;
  assign s_tready   = space;
  assign empty_name = s_tuser[0];
  assign is_dquote  = (s_tdata == CH_DQUOTE);
  // Closing quote of a quoted name: match the stripped set instead
  assign closing    = !at_start && s_tlast && opened && is_dquote;

  always_comb begin
    ctl.a_from_start = at_start;
    ctl.load_a       = 1'b0;
    ctl.load_s_start = 1'b0;
    ctl.load_s_feed  = 1'b0;
    res_load         = 1'b0;
    res_matched      = 1'b0;
    restart          = 1'b0;
    at_start_next    = at_start;
    opened_next      = opened;
    held_valid_next  = held_valid;

    if (fire) begin
      if (empty_name) begin
        // Drop whatever came before; answer for the empty name
        res_load    = 1'b1;
        res_matched = z_vec[eff_len];
        restart     = 1'b1;
      end else if (at_start) begin
        ctl.load_a       = 1'b1;
        ctl.load_s_start = 1'b1;
        at_start_next    = 1'b0;
        opened_next      = is_dquote;
        held_valid_next  = 1'b0;
        if (s_tlast) begin
          // A lone quote matches as the empty name
          res_load    = 1'b1;
          res_matched = is_dquote ? z_vec[eff_len] : a_close_vec[eff_len];
          restart     = 1'b1;
        end
      end else if (closing) begin
        res_load    = 1'b1;
        res_matched = held_valid ? s_close_vec[eff_len] : s_cur_vec[eff_len];
        restart     = 1'b1;
      end else begin
        ctl.load_a = 1'b1;
        if (opened) begin
          // Advance the stripped set by the held byte, hold this one
          ctl.load_s_feed = held_valid;
          held_valid_next = 1'b1;
        end
        if (s_tlast) begin
          res_load    = 1'b1;
          res_matched = a_close_vec[eff_len];
          restart     = 1'b1;
        end
      end

      if (restart) begin
        at_start_next   = 1'b1;
        opened_next     = 1'b0;
        held_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start   <= 1'b1;
      opened     <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      at_start   <= at_start_next;
      opened     <= opened_next;
      held_valid <= held_valid_next;
    end
  end

  // One-byte delay for the stripped set
  always_ff @(posedge clk) begin
    if (fire && !at_start && !empty_name && !closing && opened) begin
      held_byte <= s_tdata;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  wnm_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .matched_in (res_matched),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .space      (space)
  );

endmodule

@@ src/wnm_checker.sv @@
// Port-level checks for the wildcard name matcher, bound to the top level.
// Depends on wnm_pkg and wildcard_name_matcher_core.
module wnm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic [0:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import wnm_pkg::*;

  logic ends_name;
  assign ends_name = s_tvalid && s_tready && (s_tlast || s_tuser[0]);

  // Input stalls only behind an untaken result
  a_ready_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("s_tready low without a waiting result");

  // Every item that ends a name leaves a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    ends_name |=> m_tvalid)
    else $error("name ended without a result");

  // A result never appears without an item that ended a name
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ends_name))
    else $error("result without an ending item");

  // Mid-name items give nothing
  a_mid_name_silent: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tlast && !s_tuser[0] && !m_tvalid) |=> !m_tvalid)
    else $error("result from a mid-name item");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind wildcard_name_matcher_core wnm_checker u_wnm_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for wildcard_name_matcher_core: streams names at glob patterns and checks each
// match flag against a bit-set NFA predictor kept here. Depends on wnm_pkg and the core RTL.
module tb;
  import wnm_pkg::*;

  localparam int NPOS          = DEF_PATTERN_LEN + 1;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off

  typedef logic [NPOS-1:0] pos_set_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } name_item_t;

  typedef enum int {MUT_SWAP, MUT_ADD, MUT_DROP} mut_op_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic [0:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  wildcard_name_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] text_char
    .s_tlast   (s_tlast),   // last_char
    .s_tuser   (s_tuser),   // [0] empty_name
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [0] matched, [7:1] zero
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectations
  name_item_t pending_q[$];   // items waiting for the driver
  logic       matched_q[$];   // match flags still owed by the block
  name_item_t cur_item;       // item currently offered on s_*
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         fail_cnt      = 0;

  // Predictor copy of the configuration
  logic [63:0] pat_lo  = '0;
  logic [63:0] pat_hi  = '0;
  logic [4:0]  pat_len = '0;

  // Predictor copy of the name state
  pos_set_t   full_set   = pos_set_t'(1);  // every byte fed
  pos_set_t   strip_set  = pos_set_t'(1);  // opening quote dropped, bytes fed one late
  logic [7:0] late_byte  = '0;
  logic       late_ok    = 1'b0;
  logic       name_fresh = 1'b1;
  logic       quote_open = 1'b0;

  function automatic logic [7:0] pattern_byte(int i);
    if (i < REG_BYTES) return pat_lo[8*i +: 8];
    if (i < STORED_BYTES) return pat_hi[8*(i-REG_BYTES) +: 8];
    return 8'h00;
  endfunction

  // Lengths above the capacity saturate.
  function automatic int used_len();
    return (int'(pat_len) > DEF_PATTERN_LEN) ? DEF_PATTERN_LEN : int'(pat_len);
  endfunction

  // A star at a live position also makes the one after it live; ascending order chains stars.
  function automatic pos_set_t star_close(pos_set_t s, int len);
    for (int i = 0; i < len; i++)
      if (s[i] && pattern_byte(i) == CH_STAR) s[i+1] = 1'b1;
    return s;
  endfunction

  function automatic pos_set_t start_set(int len);
    return star_close(pos_set_t'(1), len);
  endfunction

  function automatic pos_set_t feed_byte(pos_set_t s, logic [7:0] c, int len);
    pos_set_t   nxt;
    logic [7:0] p;
    nxt = '0;
    for (int i = 0; i < len; i++) begin
      if (s[i]) begin
        p = pattern_byte(i);
        if (p == CH_STAR) nxt[i] = 1'b1;
        if (p == CH_QMARK || p == c) nxt[i+1] = 1'b1;
      end
    end
    return star_close(nxt, len);
  endfunction

  function automatic void name_restart();
    full_set   = pos_set_t'(1);
    strip_set  = pos_set_t'(1);
    late_byte  = '0;
    late_ok    = 1'b0;
    name_fresh = 1'b1;
    quote_open = 1'b0;
  endfunction

  // Advance the glob NFA by one accepted item; queue the match flag when a name ends.
  function automatic void glob_step(name_item_t it);
    int len;
    len = used_len();
    if (it.empty) begin
      full_set = start_set(len);
      matched_q.push_back(full_set[len]);
      name_restart();
      return;
    end
    if (name_fresh) begin
      full_set   = start_set(len);
      strip_set  = start_set(len);
      late_ok    = 1'b0;
      name_fresh = 1'b0;
      quote_open = (it.ch == CH_DQUOTE);
      full_set   = feed_byte(full_set, it.ch, len);
      if (!it.last) return;
      // a lone quote reads as the empty name
      matched_q.push_back(quote_open ? strip_set[len] : full_set[len]);
      name_restart();
      return;
    end
    if (it.last && quote_open && it.ch == CH_DQUOTE) begin
      // closing quote: finish the stripped set with the held byte
      if (late_ok) strip_set = feed_byte(strip_set, late_byte, len);
      matched_q.push_back(strip_set[len]);
      name_restart();
      return;
    end
    full_set = feed_byte(full_set, it.ch, len);
    if (quote_open) begin
      if (late_ok) strip_set = feed_byte(strip_set, late_byte, len);
      late_byte = it.ch;
      late_ok   = 1'b1;
    end
    if (it.last) begin
      matched_q.push_back(full_set[len]);
      name_restart();
    end
  endfunction

  // Driver: hold the offered item until taken, then advance, idling at random.
  always @(posedge clk) begin : drive_blk
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        glob_step(cur_item);
        offer = 1'b0;
      end
      if (!offer && pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_item = pending_q.pop_front();
        offer    = 1'b1;
        s_tdata  <= cur_item.ch;
        s_tlast  <= cur_item.last;
        s_tuser  <= cur_item.empty;
      end
      s_tvalid <= offer;
    end
  end

  // Monitor: compare each taken result with the oldest expected flag.
  // Twice in the run, drop tready for a long stretch so the block backs up into s_tready.
  int results_seen = 0;
  int hold_left    = 0;

  always @(posedge clk) begin : check_blk
    logic [7:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (matched_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got %02h", $time, m_tdata);
          fail_cnt++;
        end else begin
          want = {7'b0, matched_q.pop_front()};
          if (m_tdata !== want) begin
            $display("%0t: match flag mismatch, expected %02h got %02h", $time, want, m_tdata);
            fail_cnt++;
          end
        end
        results_seen++;
        if (results_seen == 40 || results_seen == 150) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when neither side has moved an item for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, matched_q.size());
      $display("[wildcard_name_matcher_core] ERROR");
      $finish;
    end
  end

  function automatic void push_item(logic [7:0] ch, logic last, logic empty);
    name_item_t it;
    it.ch    = ch;
    it.last  = last;
    it.empty = empty;
    pending_q.push_back(it);
  endfunction

  // Name bytes lean on the bytes patterns use, so matches stay frequent.
  function automatic logic [7:0] name_pick();
    case ($urandom_range(0, 9))
      0: return "a";
      1: return "b";
      2: return "c";
      3: return CH_DQUOTE;
      4: return CH_STAR;
      5: return CH_QMARK;
      6: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pattern_pick();
    case ($urandom_range(0, 9))
      0, 1: return CH_STAR;
      2: return CH_QMARK;
      3: return "a";
      4: return "b";
      5: return "c";
      6: return CH_DQUOTE;
      7: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue one name built to fit the current pattern, then perhaps broken; returns items queued.
  function automatic int queue_name();
    logic [7:0] nm[$];
    logic [7:0] p;
    int         len, n, cut;
    len = used_len();
    // the empty-name marker as a name of its own
    if ($urandom_range(0, 19) == 0) begin
      push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      return 1;
    end
    for (int i = 0; i < len; i++) begin
      p = pattern_byte(i);
      if (p == CH_STAR) repeat ($urandom_range(0, 3)) nm.push_back(name_pick());
      else if (p == CH_QMARK) nm.push_back(name_pick());
      else nm.push_back(p);
    end
    if ($urandom_range(0, 9) < 3 && nm.size() > 0) begin
      case (mut_op_t'($urandom_range(0, 2)))
        MUT_SWAP: nm[$urandom_range(0, nm.size() - 1)] = name_pick();
        MUT_ADD:  if ($urandom_range(0, 1)) nm.push_back(name_pick());
                  else nm.push_front(name_pick());
        MUT_DROP: if ($urandom_range(0, 1)) void'(nm.pop_back());
                  else void'(nm.pop_front());
        default: ;
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      nm.push_front(CH_DQUOTE);
      nm.push_back(CH_DQUOTE);
    end
    if (nm.size() == 0) nm.push_back($urandom_range(0, 1) ? CH_DQUOTE : name_pick());
    n = nm.size();
    // abandon the name part way with the empty-name marker
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(0, n - 1);
      for (int i = 0; i <= cut; i++) push_item(nm[i], 1'b0, 1'b0);
      push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      return cut + 2;
    end
    for (int i = 0; i < n; i++) push_item(nm[i], i == n - 1, 1'b0);
    return n;
  endfunction

  // Write one register and mirror it into the predictor.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PATTERN_LOW:    pat_lo  = val;
      REG_PATTERN_HIGH:   pat_hi  = val;
      REG_PATTERN_LENGTH: pat_len = val[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every result has come back, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || matched_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, int len);
    logic [CFG_DATA_W-1:0] len_word;
    // upper bits of the length word are junk that the block must ignore
    len_word      = {$urandom, $urandom};
    len_word[4:0] = len[4:0];
    if ($urandom_range(0, 1)) len_word[CFG_DATA_W-1:5] = '0;
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, len_word);
  endtask

  initial begin : stim_blk
    logic [63:0] lo, hi;
    int          len, n;
    send_idle_pct = 22;
    recv_idle_pct = 62;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset pattern is empty: only the empty name matches.
    push_item(8'hA5, 1'b0, 1'b1);                         // empty-name marker
    push_item("x", 1'b1, 1'b0);
    push_item(CH_DQUOTE, 1'b1, 1'b0);                     // lone quote
    push_item(CH_DQUOTE, 1'b0, 1'b0);                     // quoted empty name
    push_item(CH_DQUOTE, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    wait_drained();

    // "a**b?": doubled star, trailing single-byte wildcard
    load_pattern(64'h0000_003F_622A_2A61, 64'h0, 5);
    push_item("a", 1'b0, 1'b0);                           // fits
    push_item("b", 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item("a", 1'b0, 1'b0);                           // '?' left over at name end
    push_item("b", 1'b1, 1'b0);
    push_item(CH_DQUOTE, 1'b0, 1'b0);                     // quotes stripped
    push_item("a", 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item("b", 1'b0, 1'b0);
    push_item("z", 1'b0, 1'b0);
    push_item(CH_DQUOTE, 1'b1, 1'b0);
    push_item(CH_DQUOTE, 1'b0, 1'b0);                     // opening quote only: kept
    push_item("a", 1'b0, 1'b0);
    push_item("b", 1'b0, 1'b0);
    push_item("z", 1'b1, 1'b0);
    push_item("a", 1'b0, 1'b0);                           // name dropped mid-way
    push_item("b", 1'b0, 1'b0);
    push_item(8'h5A, 1'b1, 1'b1);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      wait_drained();
      // idling profile: sender light then heavy, then none at all
      send_idle_pct = (k < 4) ? 22 : (k < 8) ? 62 : 0;
      recv_idle_pct = (k < 4) ? 62 : (k < 8) ? 22 : 0;
      for (int b = 0; b < 8; b++) begin
        lo[8*b +: 8] = pattern_pick();
        hi[8*b +: 8] = pattern_pick();
      end
      if (k == 5) begin
        lo = {8{CH_STAR}};
        hi = {8{CH_STAR}};
      end else if (k == 6) begin
        lo = {8{CH_QMARK}};
        hi = {8{CH_QMARK}};
      end
      case (k)
        0, 5, 6: len = DEF_PATTERN_LEN;
        1:       len = 0;
        2:       len = 31;                               // saturates
        3:       len = DEF_PATTERN_LEN + 1;
        4:       len = 1;
        default: len = $urandom_range(0, 31);
      endcase
      load_pattern(lo, hi, len);
      n = 0;
      while (n < PHASE_ITEMS) n += queue_name();
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("[wildcard_name_matcher_core] OK");
    end else begin
      $display("[wildcard_name_matcher_core] ERROR");
    end
    $finish;
  end

endmodule
